>>> rtl/core/assert_macros.svh
// Assertion macros shared by the oscillator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define SOGO_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define SOGO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sogo_pkg.sv
// Types, constants and the sine table generator for the oscillator.
package sogo_pkg;

  localparam int ELAPSED_W  = 20;
  localparam int VALUE_W    = 32;
  localparam int TIME_W     = 48;
  localparam int AMP_W      = 24;
  localparam int FREQ_W     = 24;
  localparam int POFS_W     = 16;
  localparam int LEVEL_W    = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int SINE_W     = 31;   // table entries in [0, 2^30]
  localparam int PROD_W     = 56;   // amplitude times signed sine, plus rounding

  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF      = 32;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SINE_ONE    = 64'd1 << 30;

  // Factorial ratios (2n)(2n+1) of the Taylor series for sine.
  localparam logic [63:0] TAYLOR_DIV [8] = '{
    64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE    = 2'd0,
    REG_FREQUENCY    = 2'd1,
    REG_PHASE_OFFSET = 2'd2,
    REG_LEVEL_OFFSET = 2'd3
  } cfg_reg_e_t;

  typedef struct packed {
    logic signed [AMP_W-1:0]   amplitude;
    logic        [FREQ_W-1:0]  frequency;
    logic        [POFS_W-1:0]  phase_offset;
    logic signed [LEVEL_W-1:0] level_offset;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    amplitude:    24'sh010000,
    frequency:    24'h010000,
    phase_offset: 16'h0000,
    level_offset: 32'sh00010000
  };

  typedef enum logic [1:0] {
    BK_FILL,
    BK_IDLE,
    BK_LOOK,
    BK_SUM
  } bk_state_t;

  // Quarter-wave entry k: sin(pi/2 * k / 2^abits) in Q1.30, eight-term series.
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
                                                   input int unsigned abits);
    logic [63:0]        m;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    int                 n;
    m    = 64'd1 << abits;
    x    = (HALF_PI_Q30 * 64'(k) + (m >> 1)) >> abits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (n = 1; n < 8; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n[2:0]];
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > signed'(SINE_ONE)) begin
      sum = signed'(SINE_ONE);
    end
    return sum[SINE_W-1:0];
  endfunction

endpackage

>>> rtl/core/sogo_in_if.sv
// Tick request channel: elapsed time with valid/ready.
interface sogo_in_if;
  import sogo_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed;

  modport source(output valid, output elapsed, input ready);
  modport sink(input valid, input elapsed, output ready);
endinterface

>>> rtl/core/sogo_out_if.sv
// Result request channel: oscillator value and running time with valid/ready.
interface sogo_out_if;
  import sogo_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic        [TIME_W-1:0]  running_time;

  modport source(output valid, output value, output running_time, input ready);
  modport sink(input valid, input value, input running_time, output ready);
endinterface

>>> rtl/core/sogo_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sogo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

>>> rtl/core/sogo_queue.sv
// Short FIFO between the accumulator front end and the sine back end.
`include "assert_macros.svh"

module sogo_queue #(
  parameter int WIDTH = 80,
  parameter int DEPTH = sogo_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `SOGO_ASSERT(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH), "queue count beyond depth")
  `SOGO_ASSERT(a_push_room, push, !full, "push into a full queue")
  `SOGO_ASSERT(a_pop_data, pop, !empty, "pop from an empty queue")
endmodule

>>> rtl/core/sogo_front.sv
// Front end: accept ticks, advance the time and phase accumulators.
`include "assert_macros.svh"

module sogo_front #(
  parameter int PHASE_BITS = sogo_pkg::PHASE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  sogo_in_if.sink                                in_chan,
  input  logic [sogo_pkg::FREQ_W-1:0]            frequency,
  input  logic                                   tbl_ready,
  input  logic                                   q_full,
  output logic                                   push,
  output logic [PHASE_BITS+sogo_pkg::TIME_W-1:0] push_data
);
  import sogo_pkg::*;

  localparam int MUL_W = FREQ_W + ELAPSED_W;   // Q12.32 turns
  localparam int EXT_W = MUL_W + PHASE_BITS;

  logic                  f_vld_r, f_vld_nxt;
  logic [PHASE_BITS-1:0] inc_r, inc_nxt;
  logic [TIME_W-1:0]     ftime_r, ftime_nxt;
  logic [TIME_W-1:0]     time_acc_r, time_acc_nxt;
  logic [PHASE_BITS-1:0] phase_acc_r, phase_acc_nxt;
  logic [MUL_W-1:0]      prod;
  logic [EXT_W-1:0]      prod_ext;
  logic [TIME_W:0]       tsum;
  logic                  accept;

  assign in_chan.ready = tbl_ready && (!f_vld_r || !q_full);
  assign accept        = in_chan.valid && in_chan.ready;
  assign push          = f_vld_r && !q_full;

  // Scale turns from 32 fraction bits to the accumulator's width.
  assign prod     = MUL_W'(frequency) * MUL_W'(in_chan.elapsed);
  assign prod_ext = {prod, {PHASE_BITS{1'b0}}};
  assign tsum     = {1'b0, time_acc_r} + (TIME_W + 1)'(in_chan.elapsed);

  assign push_data = {phase_acc_r + inc_r, ftime_r};

  always_comb begin
    f_vld_nxt     = f_vld_r;
    inc_nxt       = inc_r;
    ftime_nxt     = ftime_r;
    time_acc_nxt  = time_acc_r;
    phase_acc_nxt = phase_acc_r;
    if (push) begin
      f_vld_nxt     = 1'b0;
      phase_acc_nxt = phase_acc_r + inc_r;
    end
    if (accept) begin
      f_vld_nxt    = 1'b1;
      inc_nxt      = prod_ext[32 +: PHASE_BITS];
      // Stick at the top of the time range.
      time_acc_nxt = tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];
      ftime_nxt    = time_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r     <= 1'b0;
      time_acc_r  <= '0;
      phase_acc_r <= '0;
    end else begin
      f_vld_r     <= f_vld_nxt;
      time_acc_r  <= time_acc_nxt;
      phase_acc_r <= phase_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inc_r   <= inc_nxt;
    ftime_r <= ftime_nxt;
  end

  `SOGO_ASSERT(a_time_mono, $past(rst_n), time_acc_r >= $past(time_acc_r),
               "running time went backwards")
  `SOGO_ASSERT_NXT(a_stage_hold, f_vld_r && !push, f_vld_r && $stable(inc_r),
                   "stalled increment lost")
endmodule

>>> rtl/core/sogo_back.sv
// Back end: table fill, quarter-wave lookup, gain, offset and saturation.
`include "assert_macros.svh"

module sogo_back #(
  parameter int TABLE_ADDR_BITS = sogo_pkg::TABLE_ADDR_BITS_DEF,
  parameter int PHASE_BITS      = sogo_pkg::PHASE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sogo_pkg::cfg_t                         cfg,
  input  logic                                   q_empty,
  input  logic [PHASE_BITS+sogo_pkg::TIME_W-1:0] q_head,
  output logic                                   pop,
  output logic                                   tbl_ready,
  sogo_out_if.source                             out_chan
);
  import sogo_pkg::*;

  localparam int TBL_DEPTH = (1 << TABLE_ADDR_BITS) + 1;
  localparam int AW        = TABLE_ADDR_BITS + 1;
  localparam logic [AW-1:0] TOP_ADDR = AW'(TBL_DEPTH - 1);
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'd1 << 29);

  // Quarter-wave table contents, fixed at elaboration.
  logic [SINE_W-1:0] rom_word [TBL_DEPTH];
  for (genvar g = 0; g < TBL_DEPTH; g++) begin : g_rom
    localparam logic [SINE_W-1:0] ENTRY = sine_entry(g, TABLE_ADDR_BITS);
    assign rom_word[g] = ENTRY;
  end

  bk_state_t                 state_r, state_nxt;
  logic [AW-1:0]             fill_cnt_r, fill_cnt_nxt;
  logic                      neg_r, neg_nxt;
  logic [TIME_W-1:0]         time_r, time_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic                      out_vld_r, out_vld_nxt;
  logic signed [VALUE_W-1:0] out_val_r, out_val_nxt;
  logic [TIME_W-1:0]         out_time_r, out_time_nxt;

  logic                          ram_we;
  logic [AW-1:0]                 raddr;
  logic [SINE_W-1:0]             rdata;
  logic [PHASE_BITS-1:0]         phase;
  logic [TABLE_ADDR_BITS-1:0]    idx;
  logic signed [VALUE_W-1:0]     s_val;
  logic signed [PROD_W-31:0]     scaled;
  logic signed [VALUE_W:0]       v_sum;
  logic                          out_free;

  sogo_ram #(
    .WIDTH (SINE_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_cnt_r),
    .wdata (rom_word[fill_cnt_r]),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Odd quadrants mirror the index; the upper half negates.
  assign phase = q_head[TIME_W +: PHASE_BITS]
               + (PHASE_BITS'(cfg.phase_offset) << (PHASE_BITS - POFS_W));
  assign idx   = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign raddr = phase[PHASE_BITS-2] ? (TOP_ADDR - {1'b0, idx}) : {1'b0, idx};

  assign s_val  = neg_r ? -$signed({1'b0, rdata}) : $signed({1'b0, rdata});
  assign scaled = prod_r[PROD_W-1:30];
  assign v_sum  = (VALUE_W + 1)'(scaled) + (VALUE_W + 1)'(cfg.level_offset);

  assign out_free  = !out_vld_r || out_chan.ready;
  assign tbl_ready = (state_r != BK_FILL);

  assign out_chan.valid        = out_vld_r;
  assign out_chan.value        = out_val_r;
  assign out_chan.running_time = out_time_r;

  always_comb begin
    state_nxt    = state_r;
    fill_cnt_nxt = fill_cnt_r;
    neg_nxt      = neg_r;
    time_nxt     = time_r;
    prod_nxt     = prod_r;
    out_vld_nxt  = out_vld_r;
    out_val_nxt  = out_val_r;
    out_time_nxt = out_time_r;
    ram_we       = 1'b0;
    pop          = 1'b0;
    if (out_vld_r && out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
    unique case (state_r)
      BK_FILL: begin
        ram_we = 1'b1;
        if (fill_cnt_r == TOP_ADDR) begin
          state_nxt = BK_IDLE;
        end else begin
          fill_cnt_nxt = fill_cnt_r + 1'b1;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          neg_nxt   = phase[PHASE_BITS-1];
          time_nxt  = q_head[TIME_W-1:0];
          state_nxt = BK_LOOK;
        end
      end
      BK_LOOK: begin
        prod_nxt  = cfg.amplitude * s_val + RND_HALF;
        state_nxt = BK_SUM;
      end
      BK_SUM: begin
        // Hold until the output register is free.
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_time_nxt = time_r;
          if (v_sum[VALUE_W] != v_sum[VALUE_W-1]) begin
            out_val_nxt = v_sum[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                         : {1'b0, {(VALUE_W-1){1'b1}}};
          end else begin
            out_val_nxt = v_sum[VALUE_W-1:0];
          end
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_FILL;
      fill_cnt_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    time_r     <= time_nxt;
    prod_r     <= prod_nxt;
    out_val_r  <= out_val_nxt;
    out_time_r <= out_time_nxt;
  end

  `SOGO_ASSERT_NXT(a_fill_sticky, state_r != BK_FILL, state_r != BK_FILL,
                   "table fill restarted without reset")
  `SOGO_ASSERT_NXT(a_pop_look, pop, state_r == BK_LOOK,
                   "popped request did not reach the lookup step")
  `SOGO_ASSERT(a_fill_no_out, state_r == BK_FILL, !out_vld_r,
               "result raised during table fill")
endmodule

>>> rtl/core/sine_oscillator_with_gain_offset_core.sv
// Top level of the sine oscillator with gain and offset.
// Direct digital synthesis sine oscillator. Each request on in_chan carries the
// time since the previous tick (unsigned Q4.16 s); the block adds it to a
// saturating Q32.16 running time and advances a phase accumulator in turns by
// frequency * elapsed, then adds the phase offset, looks the sine up in a
// quarter-wave table, scales by amplitude with round-half-up, adds the level
// offset and returns one saturated signed Q15.16 value plus the running time
// per request on out_chan. The front end registers each request and hands it on
// through a two-entry queue when that has room. For each request the back end
// steps through table read, multiply, and offset and saturate, holding the last
// step while the output is full, and pops no new request before it is done, as
// it shares one table port and one multiplier. After reset the quarter-wave
// table is loaded into its RAM, one entry per cycle, all 2^TABLE_ADDR_BITS + 1
// entries (1025 at the default size); in_chan.ready stays low until it is done.
// Configuration writes on cfg_we / cfg_index / cfg_wdata take effect at once
// and are meant to be made while no request is in flight; a frequency change
// only affects later increments, the accumulated phase is kept.
module sine_oscillator_with_gain_offset_core #(
  parameter int TABLE_ADDR_BITS = sogo_pkg::TABLE_ADDR_BITS_DEF,
  parameter int PHASE_BITS      = sogo_pkg::PHASE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sogo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sogo_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  sogo_in_if.sink                           in_chan,
  sogo_out_if.source                        out_chan
);
  import sogo_pkg::*;

  localparam int Q_W = PHASE_BITS + TIME_W;

  cfg_t cfg_r, cfg_nxt;

  logic           push;
  logic [Q_W-1:0] push_data;
  logic           pop;
  logic [Q_W-1:0] q_head;
  logic           q_full;
  logic           q_empty;
  logic           tbl_ready;

  // Register file: every index of the port maps to one register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_e_t'(cfg_index))
        REG_AMPLITUDE:    cfg_nxt.amplitude    = cfg_wdata[AMP_W-1:0];
        REG_FREQUENCY:    cfg_nxt.frequency    = cfg_wdata[FREQ_W-1:0];
        REG_PHASE_OFFSET: cfg_nxt.phase_offset = cfg_wdata[POFS_W-1:0];
        REG_LEVEL_OFFSET: cfg_nxt.level_offset = cfg_wdata[LEVEL_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Accumulators: one request in, one queue entry out.
  sogo_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .frequency (cfg_r.frequency),
    .tbl_ready (tbl_ready),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Decouple the accumulators from the lookup sequencer.
  sogo_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Table fill, lookup, gain, offset and the output register.
  sogo_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .PHASE_BITS      (PHASE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .tbl_ready (tbl_ready),
    .out_chan  (out_chan)
  );
endmodule

>>> verif/testbench.sv
// Self-checking testbench for the sine oscillator with gain and offset.
`timescale 1ns / 100ps

module testbench;
  import sogo_pkg::*;

  // The block runs at its default sizes; the predictor assumes a 32-bit phase.
  localparam int TBL_BITS = TABLE_ADDR_BITS_DEF;
  localparam int TBL_LEN = (1 << TBL_BITS) + 1;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;  // pi/2 in Q2.30

  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int SEG_ITEMS = 160;         // requests between two register settings
  localparam int SEGS_PER_MODE = 4;
  localparam int HOLD_AT = 1400;          // result count that starts the long stall
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [TIME_W-1:0]  running_time;
  } osc_result_t;

  typedef enum logic {
    ROW_TICK,
    ROW_WRITE
  } row_kind_t;

  // One directed step: either a register write or a tick request. For ticks,
  // data holds the elapsed time and want is used only when typed is set.
  typedef struct packed {
    row_kind_t              kind;
    cfg_reg_e_t             reg_sel;
    logic [CFG_DATA_W-1:0]  data;
    logic                   typed;
    osc_result_t            want;
  } stim_row_t;

  localparam int NUM_ROWS = 25;
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    // Right after reset: phase zero gives a zero sine, so only the level shows.
    '{ROW_TICK,  REG_AMPLITUDE,    32'h0000_0000, 1'b1, '{32'sh0001_0000, 48'h0}},
    // Quarter-turn shift puts the lookup on the table's last entry (the peak).
    '{ROW_WRITE, REG_PHASE_OFFSET, 32'h0000_4000, 1'b0, '{32'sh0, 48'h0}},
    '{ROW_WRITE, REG_AMPLITUDE,    32'h007F_FFFF, 1'b0, '{32'sh0, 48'h0}},
    '{ROW_WRITE, REG_LEVEL_OFFSET, 32'h7FFF_FFFF, 1'b0, '{32'sh0, 48'h0}},
    // Largest gain on top of the largest level: clip high.
    '{ROW_TICK,  REG_AMPLITUDE,    32'h0000_0000, 1'b1, '{32'sh7FFF_FFFF, 48'h0}},
    // Most negative gain; junk above bit 23 must be dropped.
    '{ROW_WRITE, REG_AMPLITUDE,    32'h5A80_0000, 1'b0, '{32'sh0, 48'h0}},
    '{ROW_WRITE, REG_LEVEL_OFFSET, 32'h8000_0000, 1'b0, '{32'sh0, 48'h0}},
    // Most negative gain below the most negative level: clip low.
    '{ROW_TICK,  REG_AMPLITUDE,    32'h0000_0000, 1'b1, '{32'sh8000_0000, 48'h0}},
    '{ROW_WRITE, REG_AMPLITUDE,    32'h0000_0000, 1'b0, '{32'sh0, 48'h0}},
    '{ROW_WRITE, REG_LEVEL_OFFSET, 32'h0000_0000, 1'b0, '{32'sh0, 48'h0}},
    // Zero gain: the rounding constant alone stays below one output step.
    '{ROW_TICK,  REG_AMPLITUDE,    32'h0000_0000, 1'b1, '{32'sh0, 48'h0}},
    '{ROW_WRITE, REG_AMPLITUDE,    32'h0001_0000, 1'b0, '{32'sh0, 48'h0}},
    '{ROW_WRITE, REG_PHASE_OFFSET, 32'hA5A5_FFFF, 1'b0, '{32'sh0, 48'h0}},
    '{ROW_TICK,  REG_AMPLITUDE,    32'h000F_FFFF, 1'b0, '{32'sh0, 48'h0}},
    // Largest frequency times largest elapsed: increment wraps many turns.
    '{ROW_WRITE, REG_FREQUENCY,    32'hFFFF_FFFF, 1'b0, '{32'sh0, 48'h0}},
    '{ROW_TICK,  REG_AMPLITUDE,    32'h000F_FFFF, 1'b0, '{32'sh0, 48'h0}},
    '{ROW_TICK,  REG_AMPLITUDE,    32'h0000_0001, 1'b0, '{32'sh0, 48'h0}},
    // Frequency zero: phase holds while time still runs.
    '{ROW_WRITE, REG_FREQUENCY,    32'h0000_0000, 1'b0, '{32'sh0, 48'h0}},
    '{ROW_TICK,  REG_AMPLITUDE,    32'h0008_0000, 1'b0, '{32'sh0, 48'h0}},
    '{ROW_WRITE, REG_PHASE_OFFSET, 32'h0000_8000, 1'b0, '{32'sh0, 48'h0}},
    '{ROW_WRITE, REG_LEVEL_OFFSET, 32'hFFFF_0000, 1'b0, '{32'sh0, 48'h0}},
    '{ROW_TICK,  REG_AMPLITUDE,    32'h0005_5555, 1'b0, '{32'sh0, 48'h0}},
    '{ROW_TICK,  REG_AMPLITUDE,    32'h000A_AAAA, 1'b0, '{32'sh0, 48'h0}},
    // Back to 1 Hz: the accumulated phase must survive the frequency change.
    '{ROW_WRITE, REG_FREQUENCY,    32'h0001_0000, 1'b0, '{32'sh0, 48'h0}},
    '{ROW_TICK,  REG_AMPLITUDE,    32'h0001_0000, 1'b0, '{32'sh0, 48'h0}}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sogo_in_if  tick_chan ();
  sogo_out_if res_chan ();

  sine_oscillator_with_gain_offset_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (tick_chan),
    .out_chan  (res_chan)
  );

  // Predictor state: register copy, both accumulators and the sine table.
  cfg_t                osc_cfg;
  logic [31:0]         phase_acc;
  logic [TIME_W-1:0]   time_acc;
  logic [SINE_W-1:0]   sine_quarter [TBL_LEN];

  osc_result_t pending_results[$];   // expected results, oldest first

  int errors = 0;
  int results_seen = 0;
  int hold_left = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Quarter-wave entry k: eight-term Taylor series of sin(pi/2 * k / 2^TBL_BITS)
  // in Q1.30 with truncating products, clamped to [0, 1.0].
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    int              n;
    x    = (QUARTER_TURN_Q30 * k + (64'd1 << (TBL_BITS - 1))) >> TBL_BITS;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (n = 1; n < 8; n++) begin
      term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > (64'sd1 <<< 30)) begin
      acc = 64'sd1 <<< 30;
    end
    return acc[SINE_W-1:0];
  endfunction

  function automatic void osc_model_reset();
    osc_cfg.amplitude    = 24'sh01_0000;   // 1.0
    osc_cfg.frequency    = 24'h01_0000;    // 1 Hz
    osc_cfg.phase_offset = 16'h0000;
    osc_cfg.level_offset = 32'sh0001_0000; // 1.0
    phase_acc = '0;
    time_acc  = '0;
  endfunction

  function automatic void osc_model_write(input cfg_reg_e_t sel,
                                          input logic [CFG_DATA_W-1:0] d);
    case (sel)
      REG_AMPLITUDE:    osc_cfg.amplitude    = d[AMP_W-1:0];
      REG_FREQUENCY:    osc_cfg.frequency    = d[FREQ_W-1:0];
      REG_PHASE_OFFSET: osc_cfg.phase_offset = d[POFS_W-1:0];
      REG_LEVEL_OFFSET: osc_cfg.level_offset = d[LEVEL_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance both accumulators by one tick, then sample the sine at the new time.
  function automatic osc_result_t osc_advance(input logic [ELAPSED_W-1:0] e);
    logic [TIME_W:0] t_sum;
    logic [43:0]     inc;
    logic [31:0]     p;
    logic [1:0]      quad;
    int unsigned     idx;
    longint          s;
    longint          scaled;
    longint          v;
    osc_result_t     r;
    // Saturation of the running time needs about 2^28 ticks, far beyond a run.
    t_sum    = {1'b0, time_acc} + (TIME_W + 1)'(e);
    time_acc = t_sum[TIME_W] ? '1 : t_sum[TIME_W-1:0];
    inc       = 44'(osc_cfg.frequency) * 44'(e);
    phase_acc = phase_acc + inc[31:0];
    p    = phase_acc + {osc_cfg.phase_offset, 16'h0000};
    quad = p[31:30];
    idx  = int'(p[29:30-TBL_BITS]);
    if (quad[0]) begin
      idx = (1 << TBL_BITS) - idx;
    end
    s = longint'(sine_quarter[idx]);
    if (quad[1]) begin
      s = -s;
    end
    // Round half up, then floor through the arithmetic shift.
    scaled = (longint'(osc_cfg.amplitude) * s + (64'sd1 <<< 29)) >>> 30;
    v = scaled + longint'(osc_cfg.level_offset);
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
    end
    r.value        = v[31:0];
    r.running_time = time_acc;
    return r;
  endfunction

  function automatic logic [ELAPSED_W-1:0] random_elapsed();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return ELAPSED_W'($urandom_range(255));
      3:       return ELAPSED_W'(1) << $urandom_range(ELAPSED_W - 1);
      default: return ELAPSED_W'($urandom);
    endcase
  endfunction

  // Offer one tick request, idling first at the sender's rate; enter and leave
  // just after a falling edge. Predict at the accepting edge.
  task automatic send_tick(input logic [ELAPSED_W-1:0] e, input logic typed,
                           input osc_result_t want);
    osc_result_t predicted;
    while ($urandom_range(99) < snd_idle_pct) begin
      tick_chan.valid   <= 1'b0;
      tick_chan.elapsed <= ELAPSED_W'($urandom);
      @(negedge clk);
    end
    tick_chan.valid   <= 1'b1;
    tick_chan.elapsed <= e;
    do @(posedge clk); while (tick_chan.ready !== 1'b1);
    predicted = osc_advance(e);
    if (typed) begin
      predicted = want;
    end
    pending_results = {pending_results, predicted};
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected result is back, then let the
  // pipeline settle so that a register write lands on an idle block.
  task automatic drain_results();
    tick_chan.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One write cycle, then one cycle with the enable low and junk on the data.
  task automatic write_reg(input cfg_reg_e_t sel, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= d;
    @(posedge clk);
    osc_model_write(sel, d);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= $urandom;
    @(negedge clk);
  endtask

  // Pick a new setting for all four registers, extremes in two of five to half of
  // the cases, with junk above the width of each register but the level offset.
  task automatic write_random_setting();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(3))
      0:       write_reg(REG_AMPLITUDE, {r[31:24], 24'h7F_FFFF});
      1:       write_reg(REG_AMPLITUDE, {r[31:24], 24'h80_0000});
      default: write_reg(REG_AMPLITUDE, r);
    endcase
    r = $urandom;
    case ($urandom_range(4))
      0:       write_reg(REG_FREQUENCY, {r[31:24], 24'h00_0000});
      1:       write_reg(REG_FREQUENCY, {r[31:24], 24'hFF_FFFF});
      2:       write_reg(REG_FREQUENCY, {r[31:20], 20'(r)});
      default: write_reg(REG_FREQUENCY, r);
    endcase
    r = $urandom;
    case ($urandom_range(3))
      0:       write_reg(REG_PHASE_OFFSET, {r[31:16], 16'h0000});
      1:       write_reg(REG_PHASE_OFFSET, {r[31:16], 16'hFFFF});
      default: write_reg(REG_PHASE_OFFSET, r);
    endcase
    r = $urandom;
    case ($urandom_range(4))
      0:       write_reg(REG_LEVEL_OFFSET, 32'h7FFF_FFFF);
      1:       write_reg(REG_LEVEL_OFFSET, 32'h8000_0000);
      2:       write_reg(REG_LEVEL_OFFSET, r);
      default: write_reg(REG_LEVEL_OFFSET, {{8{r[23]}}, r[23:0]});
    endcase
  endtask

  // Result side: drive ready at the falling edge, check at the rising edge.
  initial begin
    osc_result_t want;
    res_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        // Long stall so the block fills up and backs up onto the tick side.
        res_chan.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        res_chan.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
      @(posedge clk);
      if (res_chan.valid === 1'b1 && res_chan.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: value %0d running_time %0d",
                 res_chan.value, res_chan.running_time);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (res_chan.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, res_chan.value);
            errors++;
          end
          if (res_chan.running_time !== want.running_time) begin
            $error("running_time: expected %0d, got %0d",
                   want.running_time, res_chan.running_time);
            errors++;
          end
        end
        results_seen++;
        if (results_seen == HOLD_AT) begin
          hold_left = HOLD_CYCLES;
        end
      end
    end
  end

  // Watchdog: covers the table fill after reset and every stall many times over.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int k;
    int row;
    int mode;
    int seg;
    int item;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_AMPLITUDE;
    cfg_wdata         = '0;
    tick_chan.valid   = 1'b0;
    tick_chan.elapsed = '0;
    for (k = 0; k < TBL_LEN; k++) begin
      sine_quarter[k] = quarter_sine(k);
    end
    osc_model_reset();

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, no idling. The block holds ready low while it loads its
    // table; the first tick simply waits that out.
    for (row = 0; row < NUM_ROWS; row++) begin
      if (DIRECTED[row].kind == ROW_WRITE) begin
        drain_results();
        write_reg(DIRECTED[row].reg_sel, DIRECTED[row].data);
      end else begin
        send_tick(DIRECTED[row].data[ELAPSED_W-1:0], DIRECTED[row].typed,
                  DIRECTED[row].want);
      end
    end

    // Random part in three idling modes: receiver sparse, sender sparse, none.
    // Each segment starts with the sender paused until all results are back,
    // then a fresh register setting.
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          snd_idle_pct = 34;
          rcv_idle_pct = 60;
        end
        1: begin
          snd_idle_pct = 60;
          rcv_idle_pct = 34;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (seg = 0; seg < SEGS_PER_MODE; seg++) begin
        drain_results();
        write_random_setting();
        for (item = 0; item < SEG_ITEMS; item++) begin
          send_tick(random_elapsed(), 1'b0, '0);
        end
      end
    end

    // Wait out the last results, then give stray ones time to show up.
    drain_results();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
